>>> rtl/core/base64_line_wrapped_encoder_top_assert.svh
// Assertion macros shared by the encoder modules.
// Each macro expects clk and arst_n in scope.
`ifndef BASE64_LINE_WRAPPED_ENCODER_TOP_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define B64LE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64LE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/b64le_pkg.sv
package b64le_pkg;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_LINE_LENGTH = '0;

	// line length handling
	localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
	localparam logic [7:0] MIN_LINE          = 8'd4;

	// special characters
	localparam logic [7:0] PAD_CHAR = 8'd61;
	localparam logic [7:0] CR_CHAR  = 8'd13;
	localparam logic [7:0] LF_CHAR  = 8'd10;

	// group queue depth (power of two, at least 2)
	localparam int QUEUE_DEPTH = 2;

	// one complete (or final partial) group of input bytes
	typedef struct packed {
		logic [23:0] chunk;
		logic [1:0]  nbytes;
		logic        last;
	} b64le_group_t;

	// back end sequencer phase
	typedef enum logic {
		PH_CHAR,
		PH_LF
	} b64le_phase_t;

	// standard base64 alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return w + 8'd65;
		end else if (v < 6'd52) begin
			return w + 8'd71;
		end else if (v < 6'd62) begin
			return w - 8'd4;
		end else if (v == 6'd62) begin
			return 8'd43;
		end else begin
			return 8'd47;
		end
	endfunction

endpackage

>>> rtl/core/b64le_if.sv
// raw byte channel
interface b64le_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// encoded character channel
interface b64le_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_message;

	modport source (output valid, output out_char, output end_of_message, input ready);
	modport sink (input valid, input out_char, input end_of_message, output ready);
endinterface

>>> rtl/core/b64le_front.sv
module b64le_front (
	input  logic                    clk,
	input  logic                    arst_n,
	b64le_in_if.sink                raw,
	input  logic                    q_full,
	output logic                    push,
	output b64le_pkg::b64le_group_t push_data
);

	logic [15:0] pending_q;
	logic [1:0]  pos_q;
	logic        accept;
	logic [1:0]  pos;
	logic [7:0]  b;

	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;
	assign b         = raw.data_byte;

	// a stray position 3 behaves as a fresh group
	assign pos = (pos_q == 2'd3) ? 2'd0 : pos_q;

	// a group leaves on its third byte or on the last byte
	assign push = accept && (raw.last_byte || pos == 2'd2);

	// assemble the group word
	always_comb begin
		push_data.nbytes = pos + 2'd1;
		push_data.last   = raw.last_byte;
		case (pos)
			2'd1:    push_data.chunk = {pending_q[15:8], b, 8'h00};
			2'd2:    push_data.chunk = {pending_q, b};
			default: push_data.chunk = {b, 16'h0000};
		endcase
	end

	// held bytes and group position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			if (push) begin
				pending_q <= '0;
				pos_q     <= '0;
			end else begin
				if (pos == 2'd0) begin
					pending_q <= {b, 8'h00};
				end else begin
					pending_q <= {pending_q[15:8], b};
				end
				pos_q <= pos + 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/b64le_queue.sv
`include "base64_line_wrapped_encoder_top_assert.svh"

module b64le_queue #(
	parameter int DEPTH = b64le_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64le_pkg::b64le_group_t push_data,
	output logic                    full,
	input  logic                    pop,
	output logic                    head_valid,
	output b64le_pkg::b64le_group_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	b64le_pkg::b64le_group_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`B64LE_ASSERT_NOW(a_no_push_full, push, !full, "group pushed into full queue")
	`B64LE_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "group popped from empty queue")
	`B64LE_ASSERT_NEXT(a_count_step, push && !pop && !full, count_q != '0, "count lost a push")

endmodule

>>> rtl/core/b64le_back.sv
`include "base64_line_wrapped_encoder_top_assert.svh"

module b64le_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              line_length,
	input  logic                    head_valid,
	input  b64le_pkg::b64le_group_t head,
	output logic                    pop,
	b64le_out_if.source             enc
);

	b64le_pkg::b64le_phase_t phase_q;
	b64le_pkg::b64le_phase_t phase_d;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_eom_q;
	logic [7:0] column_q;
	logic [1:0] idx_q;

	logic       load;
	logic [7:0] lim;
	logic       brk;
	logic [5:0] sextet;
	logic       pad;
	logic [7:0] sym;
	logic       sym_eom;
	logic       emit_data;

	assign enc.valid          = out_valid_q;
	assign enc.out_char       = out_char_q;
	assign enc.end_of_message = out_eom_q;

	// output register free to take a beat
	assign load = head_valid && (!out_valid_q || enc.ready);
	assign lim  = (line_length < b64le_pkg::MIN_LINE) ? b64le_pkg::MIN_LINE : line_length;
	assign brk  = (phase_q == b64le_pkg::PH_CHAR) && (column_q >= lim);
	assign emit_data = (phase_q == b64le_pkg::PH_CHAR) && !brk;
	assign pop  = load && emit_data && (idx_q == 2'd3);

	// pick the sextet and padding for the current character
	always_comb begin
		case (idx_q)
			2'd0:    sextet = head.chunk[23:18];
			2'd1:    sextet = head.chunk[17:12];
			2'd2:    sextet = head.chunk[11:6];
			default: sextet = head.chunk[5:0];
		endcase
		pad = ((idx_q == 2'd2) && (head.nbytes == 2'd1)) ||
			((idx_q == 2'd3) && (head.nbytes != 2'd3));
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			b64le_pkg::PH_CHAR: begin
				if (load && brk) begin
					phase_d = b64le_pkg::PH_LF;
				end
			end
			b64le_pkg::PH_LF: begin
				if (load) begin
					phase_d = b64le_pkg::PH_CHAR;
				end
			end
			default: phase_d = b64le_pkg::PH_CHAR;
		endcase
	end

	// character for this beat
	always_comb begin
		sym     = b64le_pkg::b64_char(sextet);
		sym_eom = 1'b0;
		case (phase_q)
			b64le_pkg::PH_LF: begin
				sym = b64le_pkg::LF_CHAR;
			end
			b64le_pkg::PH_CHAR: begin
				if (brk) begin
					sym = b64le_pkg::CR_CHAR;
				end else begin
					if (pad) begin
						sym = b64le_pkg::PAD_CHAR;
					end
					sym_eom = (idx_q == 2'd3) && head.last;
				end
			end
			default: sym = b64le_pkg::LF_CHAR;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= sym;
			out_eom_q  <= sym_eom;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= b64le_pkg::PH_CHAR;
			out_valid_q <= 1'b0;
			column_q    <= '0;
			idx_q       <= '0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (phase_q == b64le_pkg::PH_LF) begin
					column_q <= '0;
				end else if (emit_data) begin
					idx_q <= idx_q + 2'd1;
					if ((idx_q == 2'd3) && head.last) begin
						column_q <= '0;
					end else begin
						column_q <= column_q + 8'd1;
					end
				end
			end
		end
	end

	`B64LE_ASSERT_NEXT(a_cr_then_lf, load && brk, phase_q == b64le_pkg::PH_LF,
		"CR not followed by LF")
	`B64LE_ASSERT_NOW(a_eom_on_data, out_valid_q && out_eom_q,
		out_char_q != b64le_pkg::CR_CHAR && out_char_q != b64le_pkg::LF_CHAR,
		"end of message on a line break")
	`B64LE_ASSERT_NOW(a_pop_on_fourth, pop,
		idx_q == 2'd3 && phase_q == b64le_pkg::PH_CHAR,
		"group released before its fourth character")

endmodule

>>> rtl/core/base64_line_wrapped_encoder_top.sv
// Base64 encoder with CR LF line wrapping.
// raw: one byte per beat (data_byte, last_byte); last_byte closes a message
//   and pads a partial group. enc: one ASCII character per beat (out_char,
//   end_of_message), end_of_message set on the final character only.
// APB port: register 0 at address 0 is line_length (8 bits, reset 76,
//   values below 4 act as 4). Write it only while the block is idle.
// The byte that completes a group writes it into the queue; its first
//   character is registered for enc once the group heads the queue.
// Throughput: the input takes a byte every cycle while the group queue has
//   room. The output register emits one character per cycle while the
//   receiver is ready and a group waits; three bytes give four characters,
//   plus CR LF per break; the back end sequencer sets the sustained rate.
// Reset clears the held bytes, column count, queue and output valid flag,
//   and sets line_length to 76.
// When the receiver stalls, the current character holds on enc; the queue
//   fills and then raw.ready drops until the back end drains it.
module base64_line_wrapped_encoder_top #(
	parameter int QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	b64le_in_if.sink                      raw,
	b64le_out_if.source                   enc,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [b64le_pkg::APB_AW-1:0] paddr,
	input  logic [b64le_pkg::APB_DW-1:0] pwdata,
	output logic [b64le_pkg::APB_DW-1:0] prdata,
	output logic                          pready
);

	logic [7:0]              line_length_q;
	logic                    reg_hit;
	logic                    q_full;
	logic                    push;
	b64le_pkg::b64le_group_t push_data;
	logic                    pop;
	logic                    head_valid;
	b64le_pkg::b64le_group_t head;

	// register decode
	assign pready  = 1'b1;
	assign reg_hit = (paddr[b64le_pkg::APB_AW-1:2] == b64le_pkg::REG_LINE_LENGTH);
	assign prdata  = reg_hit ? {{(b64le_pkg::APB_DW-8){1'b0}}, line_length_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= b64le_pkg::LINE_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			line_length_q <= pwdata[7:0];
		end
	end

	b64le_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	b64le_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	b64le_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (line_length_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.enc         (enc)
	);

endmodule
